// ===== rtl/lpp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the lidar point to pixel projection
// used by lpp_mac, lpp_div and lidar_point_to_pixel_projection
package lpp_pkg;

    localparam int IMG_WIDTH  = 640;
    localparam int IMG_HEIGHT = 480;

    // quotient bits; 2**QB covers the larger image side
    localparam int IMG_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
    localparam int QB      = ($clog2(IMG_MAX) > 0) ? $clog2(IMG_MAX) : 1;
    localparam int NS      = QB + 1;
    localparam int LINW    = 2 * QB + 1;

    localparam logic [QB:0] COL_LIM = (QB+1)'(IMG_WIDTH);
    localparam logic [QB:0] ROW_LIM = (QB+1)'(IMG_HEIGHT);

    localparam logic signed [31:0] MIN_FORWARD_RST = 32'sd16384;

    typedef enum logic [2:0] {
        CFG_ROW0_01     = 3'd0,
        CFG_ROW0_23     = 3'd1,
        CFG_ROW1_01     = 3'd2,
        CFG_ROW1_23     = 3'd3,
        CFG_ROW2_01     = 3'd4,
        CFG_ROW2_23     = 3'd5,
        CFG_MIN_FORWARD = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REASON_KEPT  = 2'd0,
        REASON_NEAR  = 2'd1,
        REASON_RANGE = 2'd2
    } reason_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic        keep;
        logic [1:0]  reject_reason;
        logic [9:0]  pixel_col;
        logic [8:0]  pixel_row;
        logic [18:0] pixel_index;
    } result_t;

    // row sums as sign and magnitude, from the mac stages
    typedef struct packed {
        logic        near;
        logic        n0;
        logic        n1;
        logic        n2;
        logic [63:0] m0;
        logic [63:0] m1;
        logic [63:0] m2;
    } mag_t;

    // one stage of the shared-divisor long division
    typedef struct packed {
        logic        near;
        logic        zero;
        logic        n0;
        logic        n1;
        logic        n2;
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] d;
        logic [QB:0] q0;
        logic [QB:0] q1;
    } div_t;

endpackage

// ===== rtl/lidar_point_to_pixel_projection.sv =====
`timescale 1ns / 1ps
// top level: projection matrix registers, pipeline and result register
// depends on lpp_pkg, lpp_mac, lpp_div
//
//  channel | signals                              | moves
//  in      | in_valid, in_ready, in_data          | one point item (x, y, z)
//  out     | out_valid, out_ready, out_data       | one result item per point
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | one register write
//
// one item per cycle unless a held result stalls the pipeline; the stages are:
// three mac stages, one division stage per quotient bit plus one, one output stage
// the whole pipeline advances together; a held result stalls every stage
// reset clears valid bits, zeroes the matrix and sets min_forward to 0.25
module lidar_point_to_pixel_projection
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lpp_pkg::point_t        in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lpp_pkg::result_t       out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data
);

    logic [5:0][63:0]        coef_reg;
    logic signed [31:0]      minf_reg;
    logic                    en;
    logic                    mac_vld, div_vld;
    lpp_pkg::mag_t           mag;
    lpp_pkg::div_t           quo;
    logic                    out_valid_reg;
    lpp_pkg::result_t        res_reg, res_next;
    logic [lpp_pkg::QB-1:0]  u, v;
    logic                    col_ok, row_ok;
    logic [lpp_pkg::LINW-1:0] lin;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            minf_reg <= lpp_pkg::MIN_FORWARD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (lpp_pkg::cfg_idx_t'(cfg_index))
                lpp_pkg::CFG_ROW0_01:     coef_reg[0] <= cfg_data;
                lpp_pkg::CFG_ROW0_23:     coef_reg[1] <= cfg_data;
                lpp_pkg::CFG_ROW1_01:     coef_reg[2] <= cfg_data;
                lpp_pkg::CFG_ROW1_23:     coef_reg[3] <= cfg_data;
                lpp_pkg::CFG_ROW2_01:     coef_reg[4] <= cfg_data;
                lpp_pkg::CFG_ROW2_23:     coef_reg[5] <= cfg_data;
                lpp_pkg::CFG_MIN_FORWARD: minf_reg    <= $signed(cfg_data[31:0]);
                default:                  ;
            endcase
        end
    end

    lpp_mac u_mac
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_vld      (in_valid),
        .pt          (in_data),
        .coef        (coef_reg),
        .min_forward (minf_reg),
        .out_vld     (mac_vld),
        .mag         (mag)
    );

    lpp_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (mac_vld),
        .mag     (mag),
        .out_vld (div_vld),
        .quo     (quo)
    );

    // range checks, pixel index and reject reason
    always_comb
    begin
        u      = quo.q0[lpp_pkg::QB-1:0];
        v      = quo.q1[lpp_pkg::QB-1:0];
        col_ok = !quo.q0[lpp_pkg::QB]
                 && ((u == '0) || ((quo.n0 == quo.n2) && (quo.q0 < lpp_pkg::COL_LIM)));
        row_ok = !quo.q1[lpp_pkg::QB]
                 && ((v == '0) || ((quo.n1 == quo.n2) && (quo.q1 < lpp_pkg::ROW_LIM)));
        lin    = lpp_pkg::LINW'(v) * lpp_pkg::LINW'(lpp_pkg::IMG_WIDTH)
                 + lpp_pkg::LINW'(u);
        res_next = '0;
        priority if (quo.near)
        begin
            res_next.reject_reason = lpp_pkg::REASON_NEAR;
        end
        else if (quo.zero || !col_ok || !row_ok)
        begin
            res_next.reject_reason = lpp_pkg::REASON_RANGE;
        end
        else
        begin
            res_next.keep          = 1'b1;
            res_next.reject_reason = lpp_pkg::REASON_KEPT;
            res_next.pixel_col     = 10'(u);
            res_next.pixel_row     = 9'(v);
            res_next.pixel_index   = 19'(lin);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

endmodule

// ===== rtl/lpp_mac.sv =====
`timescale 1ns / 1ps
// multiply, sum and magnitude stages of the projection (three registers)
// depends on lpp_pkg
module lpp_mac
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  lpp_pkg::point_t      pt,
    input  logic [5:0][63:0]     coef,
    input  logic signed [31:0]   min_forward,
    output logic                 out_vld,
    output lpp_pkg::mag_t        mag
);

    logic                      v1_reg, v2_reg, v3_reg;
    logic                      near1_reg, near2_reg;
    logic signed [63:0]        prod_reg [3][3];
    logic signed [63:0]        prod_next [3][3];
    logic signed [31:0]        c3_reg [3];
    logic signed [65:0]        sum_reg [3];
    logic signed [65:0]        sum_next [3];
    lpp_pkg::mag_t             mag_reg, mag_next;

    // products of coefficients and coordinates
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_next[r][0] = $signed(coef[2*r][31:0])    * pt.point_x;
            prod_next[r][1] = $signed(coef[2*r][63:32])   * pt.point_y;
            prod_next[r][2] = $signed(coef[2*r+1][31:0])  * pt.point_z;
        end
    end

    // exact row sums, constant column scaled to q32.32
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1])
                        + 66'(prod_reg[r][2]) + (66'(c3_reg[r]) <<< 16);
        end
    end

    // sign and magnitude
    always_comb
    begin
        mag_next.near = near2_reg;
        mag_next.n0   = sum_reg[0][65];
        mag_next.n1   = sum_reg[1][65];
        mag_next.n2   = sum_reg[2][65];
        mag_next.m0   = sum_reg[0][65] ? 64'(-sum_reg[0]) : 64'(sum_reg[0]);
        mag_next.m1   = sum_reg[1][65] ? 64'(-sum_reg[1]) : 64'(sum_reg[1]);
        mag_next.m2   = sum_reg[2][65] ? 64'(-sum_reg[2]) : 64'(sum_reg[2]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near1_reg <= pt.point_x < min_forward;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
                c3_reg[r]  <= $signed(coef[2*r+1][63:32]);
                sum_reg[r] <= sum_next[r];
            end
            near2_reg <= near1_reg;
            mag_reg   <= mag_next;
        end
    end

    assign out_vld = v3_reg;
    assign mag     = mag_reg;

endmodule

// ===== rtl/lpp_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring division of two row sums by the depth sum
// one quotient bit per stage, top bit flags a quotient of 2**QB or more; uses lpp_pkg
module lpp_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  lpp_pkg::mag_t     mag,
    output logic              out_vld,
    output lpp_pkg::div_t     quo
);

    localparam int DW = 64 + lpp_pkg::QB;

    lpp_pkg::div_t pipe_in   [lpp_pkg::NS];
    lpp_pkg::div_t pipe_next [lpp_pkg::NS];
    lpp_pkg::div_t pipe_reg  [lpp_pkg::NS];
    logic          vld_reg   [lpp_pkg::NS];

    // entry of the first stage
    always_comb
    begin
        pipe_in[0]      = '0;
        pipe_in[0].near = mag.near;
        pipe_in[0].zero = (mag.m2 == 64'd0);
        pipe_in[0].n0   = mag.n0;
        pipe_in[0].n1   = mag.n1;
        pipe_in[0].n2   = mag.n2;
        pipe_in[0].r0   = mag.m0;
        pipe_in[0].r1   = mag.m1;
        pipe_in[0].d    = mag.m2;
    end

    for (genvar s = 0; s < lpp_pkg::NS; s++)
    begin : g_stage
        localparam int K = lpp_pkg::NS - 1 - s;
        logic [DW-1:0] trial;

        if (s > 0)
        begin : g_link
            assign pipe_in[s] = pipe_reg[s-1];
        end

        // compare and subtract for quotient bit K
        always_comb
        begin
            trial        = DW'(pipe_in[s].d) << K;
            pipe_next[s] = pipe_in[s];
            if (DW'(pipe_in[s].r0) >= trial)
            begin
                pipe_next[s].r0    = pipe_in[s].r0 - trial[63:0];
                pipe_next[s].q0[K] = 1'b1;
            end
            if (DW'(pipe_in[s].r1) >= trial)
            begin
                pipe_next[s].r1    = pipe_in[s].r1 - trial[63:0];
                pipe_next[s].q1[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= (s == 0) ? in_vld : vld_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    assign out_vld = vld_reg[lpp_pkg::NS-1];
    assign quo     = pipe_reg[lpp_pkg::NS-1];

endmodule
